// File: design/stepper_position_driver_top_macros.svh
// Assertion macros used by the checker file design/spd_checker.sv.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STEPPER_POSITION_DRIVER_TOP_MACROS_SVH
`define STEPPER_POSITION_DRIVER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/spd_pkg.sv
package spd_pkg;

    // Sizes
    localparam int PHASE_COUNT = 8;
    localparam int POS_WIDTH   = 16;
    localparam int PHASE_W     = $clog2(PHASE_COUNT);
    localparam int HOLD_W      = 7;
    localparam int PRESCALE_W  = 4;
    localparam int VALUE_W     = 16;
    localparam int COILS_W     = 4;
    localparam int KIND_W      = 3;
    localparam int SPEED_W     = 2;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;

    typedef logic [POS_WIDTH-1:0]  pos_t;
    typedef logic [VALUE_W-1:0]    pos_out_t;
    typedef logic [PHASE_W-1:0]    phase_t;
    typedef logic [HOLD_W-1:0]     hold_t;
    typedef logic [PRESCALE_W-1:0] prescale_t;
    typedef logic [COILS_W-1:0]    coils_t;
    typedef logic [SPEED_W-1:0]    speed_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK       = 3'd0,
        KIND_SET_TARGET = 3'd1,
        KIND_SET_POS    = 3'd2,
        KIND_STOP       = 3'd3,
        KIND_ZERO       = 3'd4,
        KIND_ARM_HOLD   = 3'd5
    } kind_t;

    // Speed modes
    localparam speed_t SPEED_FAST = 2'd0;
    localparam speed_t SPEED_SLOW = 2'd1;
    localparam speed_t SPEED_HALF = 2'd2;

    // Register indexes (byte address bits [3:2])
    localparam reg_idx_t REG_DRIVE_KIND = 2'd0;
    localparam reg_idx_t REG_SPEED_MODE = 2'd1;
    localparam reg_idx_t REG_TEST_HOLD  = 2'd2;

    // Hold lengths and prescaler reloads
    localparam hold_t     HOLD_FAST   = 7'd79;
    localparam hold_t     HOLD_SLOW   = 7'd5;
    localparam prescale_t RELOAD_SLOW = 4'd12;
    localparam prescale_t RELOAD_HALF = 4'd1;

    localparam phase_t PHASE_LAST = phase_t'(PHASE_COUNT - 1);

    // Coil patterns per phase: half-step set runs in reverse, full-step repeats
    localparam coils_t COIL_HALF [8] = '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};
    localparam coils_t COIL_FULL [8] = '{4'h3, 4'h9, 4'hC, 4'h6, 4'h3, 4'h9, 4'hC, 4'h6};

    // One result
    typedef struct packed {
        coils_t   coils;
        pos_out_t position;
        logic     at_target;
    } rsp_t;

    function automatic coils_t phase_coils(input logic full_step, input phase_t idx);
        logic [2:0] i;
        i = 3'(idx);
        return full_step ? COIL_FULL[i] : COIL_HALF[i];
    endfunction

    function automatic hold_t hold_len(input speed_t speed);
        return (speed == SPEED_SLOW || speed == SPEED_HALF) ? HOLD_SLOW : HOLD_FAST;
    endfunction

endpackage

// File: design/spd_if.sv
// Request channel: one tick or command
interface spd_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [spd_pkg::KIND_W-1:0]          kind;
    logic signed [spd_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// Result channel: coil drive and position after each request
interface spd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spd_pkg::COILS_W-1:0]   coils;
    logic signed [spd_pkg::VALUE_W-1:0] position;
    logic                          at_target;

    modport source (output valid, output coils, output position, output at_target,
                    input ready);
    modport sink   (input valid, input coils, input position, input at_target,
                    output ready);
endinterface

// File: design/stepper_position_driver_top.sv
// Single-channel stepper position driver.
// cmd carries one request per handshake: a tick, set target, set position,
// stop, zero positions or arm hold; value holds the position for the set kinds.
// rsp returns exactly one result per request: the coil drive, the current
// position and an at-target flag, in request order.
// The result reaches rsp in the cycle after acceptance unless earlier results wait.
// Throughput: one request per cycle while cmd.ready is high; the whole state update is one
// combinational pass from the state registers into the result register.
// A two-deep output buffer (result register plus skid register) lets a new
// request in while one result waits; cmd.ready drops only when both are full,
// so a stalled receiver holds the block after two pending results.
// Reset (rst_n low, asynchronous) clears positions, counters, phase, coils
// (all windings off), the output buffer and the configuration registers.
// Configuration is an APB-style port: drive_kind at 0x0, speed_mode at 0x4,
// test_hold at 0x8; pready is always high. Write it only while idle.
module stepper_position_driver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    spd_cmd_if.sink                       cmd,
    spd_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spd_pkg::PADDR_W-1:0]   paddr,
    input  logic [spd_pkg::PDATA_W-1:0]   pwdata,
    output logic [spd_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // Configuration registers
    logic                  drive_kind_reg;
    spd_pkg::speed_t       speed_mode_reg;
    logic                  test_hold_reg;

    // Motion state
    spd_pkg::pos_t         target_pos_reg,     target_pos_next;
    spd_pkg::pos_t         current_pos_reg,    current_pos_next;
    spd_pkg::pos_t         steps_left_reg,     steps_left_next;
    spd_pkg::hold_t        hold_before_reg,    hold_before_next;
    spd_pkg::hold_t        hold_after_reg,     hold_after_next;
    spd_pkg::prescale_t    prescale_count_reg, prescale_count_next;
    spd_pkg::phase_t       phase_index_reg,    phase_index_next;
    spd_pkg::coils_t       coil_drive_reg,     coil_drive_next;

    // Output buffer
    logic                  out_valid_reg,  out_valid_next;
    spd_pkg::rsp_t         out_data_reg,   out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    spd_pkg::rsp_t         skid_data_reg,  skid_data_next;

    logic                  accept;
    logic                  pop;
    logic                  cfg_write;
    logic                  step_en;
    spd_pkg::reg_idx_t     reg_idx;
    spd_pkg::pos_t         value_pos;
    spd_pkg::hold_t        hold_load;
    spd_pkg::rsp_t         result;

    assign accept    = cmd.valid && cmd.ready;
    assign pop       = out_valid_reg && rsp.ready;
    assign cmd.ready = !skid_valid_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[3:2];
    assign value_pos = spd_pkg::pos_t'(cmd.value);
    assign hold_load = spd_pkg::hold_len(speed_mode_reg);

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_kind_reg <= 1'b0;
            speed_mode_reg <= spd_pkg::SPEED_FAST;
            test_hold_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                spd_pkg::REG_DRIVE_KIND: drive_kind_reg <= pwdata[0];
                spd_pkg::REG_SPEED_MODE: speed_mode_reg <= pwdata[spd_pkg::SPEED_W-1:0];
                spd_pkg::REG_TEST_HOLD:  test_hold_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            spd_pkg::REG_DRIVE_KIND: prdata[0] = drive_kind_reg;
            spd_pkg::REG_SPEED_MODE: prdata[spd_pkg::SPEED_W-1:0] = speed_mode_reg;
            spd_pkg::REG_TEST_HOLD:  prdata[0] = test_hold_reg;
            default: prdata = '0;
        endcase
    end

    // Apply one request to the motion state
    always_comb
    begin
        target_pos_next     = target_pos_reg;
        current_pos_next    = current_pos_reg;
        steps_left_next     = steps_left_reg;
        hold_before_next    = hold_before_reg;
        hold_after_next     = hold_after_reg;
        prescale_count_next = prescale_count_reg;
        phase_index_next    = phase_index_reg;
        coil_drive_next     = coil_drive_reg;
        step_en             = 1'b0;

        if (accept)
        begin
            case (spd_pkg::kind_t'(cmd.kind))
                spd_pkg::KIND_TICK:
                begin
                    if (!test_hold_reg)
                    begin
                        // Start a move when idle and away from the target
                        if (steps_left_reg == '0 && target_pos_reg != current_pos_reg)
                        begin
                            steps_left_next  = target_pos_reg - current_pos_reg;
                            hold_before_next = hold_load;
                            hold_after_next  = hold_load;
                        end

                        // Prescaler swallows ticks at the slow speeds
                        step_en = 1'b1;
                        if (speed_mode_reg inside {spd_pkg::SPEED_SLOW, spd_pkg::SPEED_HALF})
                        begin
                            if (prescale_count_reg != '0)
                            begin
                                prescale_count_next = prescale_count_reg
                                                      - spd_pkg::prescale_t'(1);
                                step_en = 1'b0;
                            end
                            else
                            begin
                                prescale_count_next = (speed_mode_reg == spd_pkg::SPEED_SLOW)
                                                      ? spd_pkg::RELOAD_SLOW
                                                      : spd_pkg::RELOAD_HALF;
                            end
                        end

                        // Hold, release or advance one phase
                        if (step_en)
                        begin
                            if (hold_before_next != '0)
                            begin
                                hold_before_next = hold_before_next - spd_pkg::hold_t'(1);
                                coil_drive_next  = spd_pkg::phase_coils(drive_kind_reg,
                                                                        phase_index_reg);
                            end
                            else if (steps_left_next == '0)
                            begin
                                if (hold_after_next != '0)
                                begin
                                    hold_after_next = hold_after_next - spd_pkg::hold_t'(1);
                                    coil_drive_next = spd_pkg::phase_coils(drive_kind_reg,
                                                                           phase_index_reg);
                                end
                                else
                                begin
                                    coil_drive_next = '0;
                                end
                            end
                            else if (!steps_left_next[spd_pkg::POS_WIDTH-1])
                            begin
                                steps_left_next  = steps_left_next - spd_pkg::pos_t'(1);
                                current_pos_next = current_pos_reg + spd_pkg::pos_t'(1);
                                phase_index_next = (phase_index_reg == spd_pkg::PHASE_LAST)
                                                   ? '0
                                                   : phase_index_reg + spd_pkg::phase_t'(1);
                                coil_drive_next  = spd_pkg::phase_coils(drive_kind_reg,
                                                                        phase_index_next);
                            end
                            else
                            begin
                                steps_left_next  = steps_left_next + spd_pkg::pos_t'(1);
                                current_pos_next = current_pos_reg - spd_pkg::pos_t'(1);
                                phase_index_next = (phase_index_reg == '0)
                                                   ? spd_pkg::PHASE_LAST
                                                   : phase_index_reg - spd_pkg::phase_t'(1);
                                coil_drive_next  = spd_pkg::phase_coils(drive_kind_reg,
                                                                        phase_index_next);
                            end
                        end
                    end
                end
                spd_pkg::KIND_SET_TARGET: target_pos_next = value_pos;
                spd_pkg::KIND_SET_POS:    current_pos_next = value_pos;
                spd_pkg::KIND_STOP:
                begin
                    target_pos_next  = current_pos_reg;
                    steps_left_next  = '0;
                    hold_before_next = hold_load;
                    hold_after_next  = hold_load;
                end
                spd_pkg::KIND_ZERO:
                begin
                    target_pos_next  = '0;
                    current_pos_next = '0;
                end
                spd_pkg::KIND_ARM_HOLD:
                begin
                    hold_before_next = hold_load;
                    hold_after_next  = hold_load;
                end
                default: ;
            endcase
        end
    end

    // Build the result from the updated state
    always_comb
    begin
        result.coils     = coil_drive_next;
        result.position  = spd_pkg::pos_out_t'(current_pos_next);
        result.at_target = (target_pos_next == current_pos_next);
    end

    // Advance the output buffer: head register plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = accept;
                skid_data_next  = result;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pos_reg     <= '0;
            current_pos_reg    <= '0;
            steps_left_reg     <= '0;
            hold_before_reg    <= '0;
            hold_after_reg     <= '0;
            prescale_count_reg <= '0;
            phase_index_reg    <= '0;
            coil_drive_reg     <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            target_pos_reg     <= target_pos_next;
            current_pos_reg    <= current_pos_next;
            steps_left_reg     <= steps_left_next;
            hold_before_reg    <= hold_before_next;
            hold_after_reg     <= hold_after_next;
            prescale_count_reg <= prescale_count_next;
            phase_index_reg    <= phase_index_next;
            coil_drive_reg     <= coil_drive_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.coils     = out_data_reg.coils;
    assign rsp.position  = out_data_reg.position;
    assign rsp.at_target = out_data_reg.at_target;

endmodule

// File: design/spd_checker.sv
`include "stepper_position_driver_top_macros.svh"

module spd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [spd_pkg::COILS_W-1:0]   rsp_coils,
    input logic [spd_pkg::VALUE_W-1:0]   rsp_position,
    input logic                          rsp_at_target
);

    // A stalled result holds its payload
    `SPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_coils) && $stable(rsp_position) && $stable(rsp_at_target), "stalled result changed")

    // Every accepted request leaves a result pending in the next cycle
    `SPD_ASSERT_NEXT(a_rsp_follows, cmd_valid && cmd_ready, rsp_valid, "accepted request gave no result")

    // An empty output buffer never backpressures requests
    `SPD_ASSERT_SAME(a_ready_when_empty, !rsp_valid, cmd_ready, "ready low with no result pending")

    // Coils show only windings-off or a pattern from the phase tables
    `SPD_ASSERT_SAME(a_coil_pattern, rsp_valid, !(rsp_coils == 4'h5 || rsp_coils == 4'h7 || rsp_coils == 4'hA || rsp_coils == 4'hB || rsp_coils == 4'hD || rsp_coils == 4'hE || rsp_coils == 4'hF), "illegal coil pattern")

endmodule

bind stepper_position_driver_top spd_checker u_spd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_coils     (rsp.coils),
    .rsp_position  (rsp.position),
    .rsp_at_target (rsp.at_target)
);

// File: tb/sv/spd_checker.sv
module spd_scoreboard
    import spd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    spd_cmd_if                 cmd,
    spd_rsp_if                 rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatches,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam hold_t     LONG_HOLD   = 7'd79;
    localparam hold_t     SHORT_HOLD  = 7'd5;
    localparam prescale_t SLOW_RELOAD = 4'd12;
    localparam prescale_t HALF_RELOAD = 4'd1;

    // Half-step patterns indexed by phase 0 to 7; full-step repeats its four patterns twice
    localparam coils_t HALF_STEP_COILS [8] = '{4'h8, 4'hC, 4'h4, 4'h6,
                                               4'h2, 4'h3, 4'h1, 4'h9};
    localparam coils_t FULL_STEP_COILS [8] = '{4'h3, 4'h9, 4'hC, 4'h6,
                                               4'h3, 4'h9, 4'hC, 4'h6};

    // Shadow of the configuration registers
    logic   full_step    = 1'b0;
    speed_t speed        = SPEED_FAST;
    logic   ticks_frozen = 1'b0;

    // Shadow of the motor state
    pos_t      goal       = '0;
    pos_t      here       = '0;
    pos_t      remaining  = '0;
    hold_t     start_hold = '0;
    hold_t     stop_hold  = '0;
    prescale_t tick_div   = '0;
    phase_t    phase      = '0;
    coils_t    winding    = '0;

    rsp_t expected_q [$];
    int   fail_count    = 0;
    int   pending_count = 0;

    assign mismatches = fail_count;
    assign pending    = pending_count;

    function automatic hold_t hold_for_speed();
        return (speed == SPEED_SLOW || speed == SPEED_HALF) ? SHORT_HOLD : LONG_HOLD;
    endfunction

    function automatic coils_t pattern_now();
        return full_step ? FULL_STEP_COILS[phase] : HALF_STEP_COILS[phase];
    endfunction

    task automatic reload_holds();
        start_hold = hold_for_speed();
        stop_hold  = hold_for_speed();
    endtask

    // Advance the motor shadow by one request and return the coil drive, position and at-target flag it leaves
    task automatic apply_request(input logic [KIND_W-1:0] kind,
                                 input logic [VALUE_W-1:0] value,
                                 output rsp_t res);
        logic take_step;
        take_step = 1'b0;
        case (kind)
            KIND_TICK:
                if (!ticks_frozen)
                begin
                    // start a new move once the last one is used up
                    if (remaining == '0 && goal != here)
                    begin
                        remaining = goal - here;
                        reload_holds();
                    end
                    take_step = 1'b1;
                    // prescaler swallows ticks at the slower speeds
                    if (speed == SPEED_SLOW || speed == SPEED_HALF)
                    begin
                        if (tick_div != '0)
                        begin
                            tick_div  = tick_div - 1'b1;
                            take_step = 1'b0;
                        end
                        else
                        begin
                            tick_div = (speed == SPEED_SLOW) ? SLOW_RELOAD : HALF_RELOAD;
                        end
                    end
                end
            KIND_SET_TARGET: goal = pos_t'($signed(value));
            KIND_SET_POS:    here = pos_t'($signed(value));
            KIND_STOP:
            begin
                goal      = here;
                remaining = '0;
                reload_holds();
            end
            KIND_ZERO:
            begin
                goal = '0;
                here = '0;
            end
            KIND_ARM_HOLD: reload_holds();
            default: ;
        endcase

        if (take_step)
        begin
            if (start_hold != '0)
            begin
                start_hold = start_hold - 1'b1;
                winding    = pattern_now();
            end
            else if (remaining == '0)
            begin
                // run the stop hold, then release all windings
                if (stop_hold != '0)
                begin
                    stop_hold = stop_hold - 1'b1;
                    winding   = pattern_now();
                end
                else
                begin
                    winding = '0;
                end
            end
            else if (!remaining[POS_WIDTH-1])
            begin
                remaining = remaining - 1'b1;
                here      = here + 1'b1;
                phase     = (phase == PHASE_COUNT - 1) ? '0 : phase + 1'b1;
                winding   = pattern_now();
            end
            else
            begin
                remaining = remaining + 1'b1;
                here      = here - 1'b1;
                phase     = (phase == '0) ? phase_t'(PHASE_COUNT - 1) : phase - 1'b1;
                winding   = pattern_now();
            end
        end

        res.coils     = winding;
        res.position  = here[VALUE_W-1:0];
        res.at_target = (goal == here);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t fresh;
        if (!rst_n)
        begin
            full_step    = 1'b0;
            speed        = SPEED_FAST;
            ticks_frozen = 1'b0;
            goal         = '0;
            here         = '0;
            remaining    = '0;
            start_hold   = '0;
            stop_hold    = '0;
            tick_div     = '0;
            phase        = '0;
            winding      = '0;
            expected_q.delete();
            pending_count = 0;
        end
        else
        begin
            // Check each result against the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result coils %h position %0d at_target %b",
                             $time, rsp.coils, rsp.position, rsp.at_target);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.coils !== want.coils)
                    begin
                        $display("%0t: coils expected %h actual %h",
                                 $time, want.coils, rsp.coils);
                        fail_count++;
                    end
                    if (rsp.position !== want.position)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, $signed(want.position), rsp.position);
                        fail_count++;
                    end
                    if (rsp.at_target !== want.at_target)
                    begin
                        $display("%0t: at_target expected %b actual %b",
                                 $time, want.at_target, rsp.at_target);
                        fail_count++;
                    end
                end
            end

            // Predict the result of each accepted request
            if (cmd.valid && cmd.ready)
            begin
                apply_request(cmd.kind, cmd.value, fresh);
                expected_q.push_back(fresh);
            end

            // Track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[PADDR_W-1:2]))
                    REG_DRIVE_KIND: full_step    = pwdata[0];
                    REG_SPEED_MODE: speed        = pwdata[SPEED_W-1:0];
                    REG_TEST_HOLD:  ticks_frozen = pwdata[0];
                    default: ;
                endcase
            end

            pending_count = expected_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spd_pkg::*;

    // Kinds and speed the block decodes as no-ops or as the fast speed
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
    localparam speed_t            SPEED_SPARE   = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatches;
    int pending;
    bit calm         = 1'b0;
    int sent_items   = 0;
    int stall_left   = 0;

    spd_cmd_if cmd_ch ();
    spd_rsp_if rsp_ch ();

    stepper_position_driver_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    spd_scoreboard motion_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_ch),
        .rsp        (rsp_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2_000_000;
        $display("stepper_position_driver_top: mismatch");
        $finish;
    end

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Stall the result side at random
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = pause_len() - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one request, after an optional gap, and hold it until accepted
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [VALUE_W-1:0] value);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? pause_len() : 0;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind  <= kind;
        cmd_ch.value <= value;
        do @(posedge clk); while (!cmd_ch.ready);
        sent_items++;
    endtask

    // Drop valid and wait until every result is back
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Setup phase then access phase; the caller closes the bus
    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Write all three registers while the block is idle, junk in the unused bits
    task automatic configure(input logic full, input speed_t speed, input logic freeze);
        logic [PDATA_W-1:0] word;
        wait_idle();
        word = $urandom;
        word[0] = full;
        write_reg(REG_DRIVE_KIND, word);
        word = $urandom;
        word[SPEED_W-1:0] = speed;
        write_reg(REG_SPEED_MODE, word);
        word = $urandom;
        word[0] = freeze;
        write_reg(REG_TEST_HOLD, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Moves near a chosen anchor followed by tick bursts, mixed with loose requests
    task automatic run_random(input int quota);
        int                 goal_count;
        int                 burst;
        int                 pick;
        logic [VALUE_W-1:0] anchor;
        goal_count = sent_items + quota;
        while (sent_items < goal_count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                // anchors at the wrap point make moves cross it
                case ($urandom_range(0, 3))
                    0: anchor = '0;
                    1: anchor = 16'h7FFE;
                    2: anchor = 16'h8001;
                    default: anchor = VALUE_W'($urandom);
                endcase
                if ($urandom_range(0, 4) != 0)
                    send_request(KIND_SET_POS, anchor + VALUE_W'($urandom_range(0, 8)) - 16'd4);
                send_request(KIND_SET_TARGET, anchor + VALUE_W'($urandom_range(0, 8)) - 16'd4);
                burst = ($urandom_range(0, 2) == 0) ? $urandom_range(100, 250)
                                                    : $urandom_range(1, 60);
                // keep the burst inside the quota
                if (burst > goal_count - sent_items)
                    burst = (goal_count > sent_items) ? goal_count - sent_items : 0;
                repeat (burst) send_request(KIND_TICK, VALUE_W'($urandom));
            end
            else if (pick < 85)
            begin
                send_request(KIND_TICK, VALUE_W'($urandom));
            end
            else
            begin
                send_request(KIND_W'($urandom_range(KIND_SET_TARGET, KIND_SPARE_HI)),
                             VALUE_W'($urandom));
            end
        end
    endtask

    initial
    begin
        cmd_ch.valid <= 1'b0;
        cmd_ch.kind  <= KIND_TICK;
        cmd_ch.value <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, wrap across the signed limit, every kind
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_SET_TARGET, 16'h7FFF);
        send_request(KIND_SET_POS, 16'h8000);
        send_request(KIND_TICK, 16'hFFFF);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_SPARE_LO, 16'h5555);
        send_request(KIND_SPARE_HI, 16'hAAAA);
        send_request(KIND_STOP, 16'hFFFF);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_ARM_HOLD, 16'h1234);
        send_request(KIND_ZERO, 16'hFFFF);
        send_request(KIND_SET_TARGET, 16'h0002);
        send_request(KIND_TICK, 16'h0000);

        // Unused speed code acts as the fast speed
        configure(1'b0, SPEED_SPARE, 1'b0);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h0000);

        // Slow speed: the prescaler swallows the ticks after a step
        configure(1'b0, SPEED_SLOW, 1'b0);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h0000);

        // Frozen ticks keep the last drive
        configure(1'b0, SPEED_SLOW, 1'b1);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_SET_POS, 16'hFFFF);

        configure(1'b1, SPEED_HALF, 1'b0);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_TICK, 16'h0000);
        send_request(KIND_STOP, 16'h0000);

        // Random phases over a spread of settings, one with no idling
        configure(1'b0, SPEED_FAST, 1'b0);
        run_random(150);
        configure(1'b1, SPEED_HALF, 1'b0);
        run_random(150);
        configure(1'b0, SPEED_SLOW, 1'b0);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;
        configure(1'b1, SPEED_SPARE, 1'b0);
        run_random(150);
        configure(1'b0, SPEED_HALF, 1'b1);
        run_random(60);
        configure(1'b1, SPEED_FAST, 1'b0);
        run_random(150);
        configure(1'($urandom_range(0, 1)), speed_t'($urandom_range(0, 3)), 1'b0);
        run_random(170);

        wait_idle();
        if (mismatches == 0)
            $display("stepper_position_driver_top: match");
        else
            $display("stepper_position_driver_top: mismatch");
        $finish;
    end

endmodule
